@@ hdl/block_average_to_ascii_glyph_core_assert.svh @@
// Assertion macros shared by the block-average glyph core RTL.
`ifndef BLOCK_AVERAGE_TO_ASCII_GLYPH_CORE_ASSERT_SVH
`define BLOCK_AVERAGE_TO_ASCII_GLYPH_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define BAAG_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define BAAG_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/baag_pkg.sv @@
// Shared constants, types and glyph table of the block-average glyph core.
`default_nettype none

package baag_pkg;

	// sizing
	localparam int MAX_COLUMNS   = 64;
	localparam int MAX_CELL_SIDE = 64;
	localparam int MAX_ROWS      = 64;
	localparam int TABLE_SIZE    = 32;

	localparam int GRAY_W     = 8;
	localparam int GLYPH_W    = 7;
	localparam int IMG_CFG_W  = 13;
	localparam int CELL_CFG_W = 7;
	localparam int SUM_W      = 20;
	localparam int AREA_W     = 13;
	localparam int MEAN_W     = 8;
	localparam int MEAN_LEVELS = 2 ** MEAN_W;
	localparam int STEP_W     = $clog2(MEAN_W + 1);
	localparam int DSH_W      = AREA_W + MEAN_W;

	localparam int PX_W    = 12;
	localparam int LINE_W  = $clog2(MAX_CELL_SIDE);
	localparam int XC_W    = $clog2(MAX_CELL_SIDE);
	localparam int CELL_W  = $clog2(MAX_COLUMNS + 1);
	localparam int BAND_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_A_W = $clog2(MAX_COLUMNS);

	// APB
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CELL_COLUMNS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CELL_ROWS    = 3'd4;

	localparam logic [IMG_CFG_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [CELL_CFG_W-1:0] RST_CELL_WIDTH   = 7'd8;
	localparam logic [CELL_CFG_W-1:0] RST_CELL_HEIGHT  = 7'd16;
	localparam logic [CELL_CFG_W-1:0] RST_CELL_COLUMNS = 7'd60;
	localparam logic [CELL_CFG_W-1:0] RST_CELL_ROWS    = 7'd30;

	localparam logic [IMG_CFG_W-1:0]  IMG_W_MAX = 13'd4096;
	localparam logic [CELL_CFG_W-1:0] SIDE_MAX  = CELL_CFG_W'(MAX_CELL_SIDE);
	localparam logic [CELL_CFG_W-1:0] COLS_MAX  = CELL_CFG_W'(MAX_COLUMNS);
	localparam logic [CELL_CFG_W-1:0] ROWS_MAX  = CELL_CFG_W'(MAX_ROWS);

	localparam int V_SCALE = 90;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} cell_tag_t;

	typedef struct packed {
		logic idle;
		logic done;
	} div_status_t;

	typedef logic [GLYPH_W-1:0] glyph_tab_t [TABLE_SIZE];
	typedef logic [7:0]         thr_tab_t   [TABLE_SIZE];
	typedef logic [GLYPH_W-1:0] glyph_lut_t [MEAN_LEVELS];

	// bright-to-dark ramp, space first and M last
	localparam glyph_tab_t GLYPH_TAB = '{
		7'h20, 7'h60, 7'h2E, 7'h5E, 7'h2C, 7'h3A, 7'h7E, 7'h22,
		7'h3C, 7'h21, 7'h63, 7'h74, 7'h2B, 7'h7B, 7'h69, 7'h37,
		7'h3F, 7'h75, 7'h33, 7'h30, 7'h70, 7'h77, 7'h34, 7'h41,
		7'h38, 7'h44, 7'h58, 7'h25, 7'h23, 7'h48, 7'h57, 7'h4D
	};

	localparam thr_tab_t THR_TAB = '{
		8'd0,  8'd5,  8'd7,  8'd9,  8'd13, 8'd15, 8'd17, 8'd19,
		8'd21, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd35,
		8'd37, 8'd39, 8'd41, 8'd43, 8'd45, 8'd47, 8'd49, 8'd51,
		8'd53, 8'd55, 8'd59, 8'd61, 8'd63, 8'd66, 8'd68, 8'd70
	};

	// mean gray -> glyph, folded at elaboration
	function automatic glyph_lut_t build_glyph_lut();
		glyph_lut_t lut;
		int unsigned v;
		int unsigned k;
		int g;
		int i;
		for (g = 0; g < MEAN_LEVELS; g++) begin
			v = ((MEAN_LEVELS - 1 - g) * V_SCALE) / (MEAN_LEVELS - 1);
			if (v <= THR_TAB[0]) begin
				lut[g] = GLYPH_TAB[0];
			end else if (v >= THR_TAB[TABLE_SIZE-1]) begin
				lut[g] = GLYPH_TAB[TABLE_SIZE-1];
			end else begin
				k = 0;
				for (i = 0; i < TABLE_SIZE; i++) begin
					if (THR_TAB[i] < v) begin
						k = i;
					end
				end
				lut[g] = GLYPH_TAB[k];
			end
		end
		return lut;
	endfunction

	localparam glyph_lut_t GLYPH_LUT = build_glyph_lut();

endpackage

`default_nettype wire

@@ hdl/baag_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module baag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/baag_div.sv @@
// Bit-serial cell-mean divider: sum / area, saturated to 8 bits.
`default_nettype none
`include "block_average_to_ascii_glyph_core_assert.svh"

module baag_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [baag_pkg::SUM_W-1:0]         num,
	input  logic [baag_pkg::AREA_W-1:0]        den,
	input  baag_pkg::cell_tag_t                start_tag,
	input  logic                               take,
	output baag_pkg::div_status_t              status,
	output logic [baag_pkg::MEAN_W-1:0]        mean,
	output baag_pkg::cell_tag_t                tag
);

	baag_pkg::div_state_t state_q, state_d;

	logic [baag_pkg::SUM_W-1:0]  rem_q;
	logic [baag_pkg::DSH_W-1:0]  dsh_q;
	logic [baag_pkg::STEP_W-1:0] step_q;
	logic [baag_pkg::MEAN_W-1:0] quo_q;
	baag_pkg::cell_tag_t         tag_q;

	logic ge;
	logic sat_step;
	logic finish;

	// first step only checks for a quotient of 256 or more
	assign ge       = baag_pkg::DSH_W'(rem_q) >= dsh_q;
	assign sat_step = step_q == baag_pkg::STEP_W'(baag_pkg::MEAN_W);
	assign finish   = (state_q == baag_pkg::DIV_RUN)
		&& (sat_step ? ge : (step_q == '0));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			baag_pkg::DIV_IDLE: begin
				if (start) state_d = baag_pkg::DIV_RUN;
			end
			baag_pkg::DIV_RUN: begin
				if (finish) state_d = baag_pkg::DIV_DONE;
			end
			baag_pkg::DIV_DONE: begin
				if (take) state_d = baag_pkg::DIV_IDLE;
			end
			default: state_d = baag_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		status.idle = state_q == baag_pkg::DIV_IDLE;
		status.done = state_q == baag_pkg::DIV_DONE;
		mean        = quo_q;
		tag         = tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= baag_pkg::DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == baag_pkg::DIV_IDLE) begin
			rem_q  <= num;
			dsh_q  <= {den, {baag_pkg::MEAN_W{1'b0}}};
			step_q <= baag_pkg::STEP_W'(baag_pkg::MEAN_W);
			quo_q  <= '0;
			tag_q  <= start_tag;
		end else if (state_q == baag_pkg::DIV_RUN) begin
			if (sat_step) begin
				if (ge) quo_q <= '1;
			end else begin
				quo_q <= {quo_q[baag_pkg::MEAN_W-2:0], ge};
				if (ge) rem_q <= rem_q - dsh_q[baag_pkg::SUM_W-1:0];
			end
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	`BAAG_ASSERT_NEXT(a_div_start_loads, start && state_q == baag_pkg::DIV_IDLE, state_q == baag_pkg::DIV_RUN && sat_step, "divider did not start at saturation step")
	`BAAG_ASSERT_IMPLY(a_div_step_range, state_q == baag_pkg::DIV_RUN, step_q <= baag_pkg::STEP_W'(baag_pkg::MEAN_W), "divider step out of range")
	`BAAG_ASSERT_NEXT(a_div_done_holds, state_q == baag_pkg::DIV_DONE && !take, state_q == baag_pkg::DIV_DONE && $stable(quo_q), "divider result lost before take")

endmodule

`default_nettype wire

@@ hdl/block_average_to_ascii_glyph_core.sv @@
// Top level: block-average downscaler from gray pixels to ASCII glyphs.
//
// Channel  Signals                                        Transfer at clk edge with
// cfg      psel penable pwrite paddr pwdata prdata pready psel & penable & pready
// pixel    in_valid in_ready pixel_gray frame_start       in_valid & in_ready
// glyph    out_valid out_ready glyph row_end frame_end    out_valid & out_ready
//
// A pixel that does not close a cell is taken every cycle.
// A pixel that closes a cell starts the bit-serial divider (one saturation check plus
// eight quotient bits, then a done state); the next cell-closing pixel waits
// until the divider is idle again, so a cell cannot close while the last mean is in work
// (a saturating mean, possible only after a mid-frame cell size change, ends at the check).
// Reset is asynchronous: config returns to its defaults, the 64 column-sum valid bits
// clear at once (no clearing pass), output and divider go empty.
// out_ready low holds the output register, then the divider result, then the next
// cell-closing pixel; other pixels keep flowing.
`default_nettype none
`include "block_average_to_ascii_glyph_core_assert.svh"

module block_average_to_ascii_glyph_core (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [baag_pkg::PADDR_W-1:0]     paddr,
	input  logic [baag_pkg::PDATA_W-1:0]     pwdata,
	output logic [baag_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [baag_pkg::GRAY_W-1:0]      pixel_gray,
	input  logic                             frame_start,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [baag_pkg::GLYPH_W-1:0]     glyph,
	output logic                             row_end,
	output logic                             frame_end
);

	// ---------------------------------------------------------------- config regs
	logic [baag_pkg::IMG_CFG_W-1:0]  image_width_q;
	logic [baag_pkg::CELL_CFG_W-1:0] cell_width_q;
	logic [baag_pkg::CELL_CFG_W-1:0] cell_height_q;
	logic [baag_pkg::CELL_CFG_W-1:0] cell_columns_q;
	logic [baag_pkg::CELL_CFG_W-1:0] cell_rows_q;

	logic                            cfg_wr;
	logic [baag_pkg::REG_IDX_W-1:0]  reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[baag_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= baag_pkg::RST_IMAGE_WIDTH;
			cell_width_q   <= baag_pkg::RST_CELL_WIDTH;
			cell_height_q  <= baag_pkg::RST_CELL_HEIGHT;
			cell_columns_q <= baag_pkg::RST_CELL_COLUMNS;
			cell_rows_q    <= baag_pkg::RST_CELL_ROWS;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				baag_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[baag_pkg::IMG_CFG_W-1:0];
				baag_pkg::REG_CELL_WIDTH:   cell_width_q   <= pwdata[baag_pkg::CELL_CFG_W-1:0];
				baag_pkg::REG_CELL_HEIGHT:  cell_height_q  <= pwdata[baag_pkg::CELL_CFG_W-1:0];
				baag_pkg::REG_CELL_COLUMNS: cell_columns_q <= pwdata[baag_pkg::CELL_CFG_W-1:0];
				baag_pkg::REG_CELL_ROWS:    cell_rows_q    <= pwdata[baag_pkg::CELL_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			baag_pkg::REG_IMAGE_WIDTH:  prdata = baag_pkg::PDATA_W'(image_width_q);
			baag_pkg::REG_CELL_WIDTH:   prdata = baag_pkg::PDATA_W'(cell_width_q);
			baag_pkg::REG_CELL_HEIGHT:  prdata = baag_pkg::PDATA_W'(cell_height_q);
			baag_pkg::REG_CELL_COLUMNS: prdata = baag_pkg::PDATA_W'(cell_columns_q);
			baag_pkg::REG_CELL_ROWS:    prdata = baag_pkg::PDATA_W'(cell_rows_q);
			default:                    prdata = '0;
		endcase
	end

	// Effective limits: registers saturate into their legal range, zero acts as one.
	logic [baag_pkg::IMG_CFG_W-1:0]  iw;
	logic [baag_pkg::CELL_CFG_W-1:0] cw, ch, cols, rows;
	logic [baag_pkg::AREA_W-1:0]     area;

	always_comb begin
		iw = (image_width_q == '0) ? baag_pkg::IMG_CFG_W'(1)
			: ((image_width_q > baag_pkg::IMG_W_MAX) ? baag_pkg::IMG_W_MAX : image_width_q);
		cw = (cell_width_q == '0) ? baag_pkg::CELL_CFG_W'(1)
			: ((cell_width_q > baag_pkg::SIDE_MAX) ? baag_pkg::SIDE_MAX : cell_width_q);
		ch = (cell_height_q == '0) ? baag_pkg::CELL_CFG_W'(1)
			: ((cell_height_q > baag_pkg::SIDE_MAX) ? baag_pkg::SIDE_MAX : cell_height_q);
		cols = (cell_columns_q == '0) ? baag_pkg::CELL_CFG_W'(1)
			: ((cell_columns_q > baag_pkg::COLS_MAX) ? baag_pkg::COLS_MAX : cell_columns_q);
		rows = (cell_rows_q == '0) ? baag_pkg::CELL_CFG_W'(1)
			: ((cell_rows_q > baag_pkg::ROWS_MAX) ? baag_pkg::ROWS_MAX : cell_rows_q);
		area = baag_pkg::AREA_W'(cw) * baag_pkg::AREA_W'(ch);
	end

	// ---------------------------------------------------------------- raster counters
	logic [baag_pkg::PX_W-1:0]   pixel_x_q,      e_px,   n_px;
	logic [baag_pkg::LINE_W-1:0] line_in_band_q, e_line, n_line;
	logic [baag_pkg::BAND_W-1:0] band_index_q,   e_band, n_band;
	logic [baag_pkg::XC_W-1:0]   x_in_cell_q,    e_xc,   n_xc;
	logic [baag_pkg::CELL_W-1:0] cell_index_q,   e_cell, n_cell;

	logic active, in_cell, line_last, x_last, px_last, col_last, band_last, completes;
	logic accept;

	// frame_start clears the counters before the pixel is placed
	always_comb begin
		e_px   = frame_start ? '0 : pixel_x_q;
		e_line = frame_start ? '0 : line_in_band_q;
		e_band = frame_start ? '0 : band_index_q;
		e_xc   = frame_start ? '0 : x_in_cell_q;
		e_cell = frame_start ? '0 : cell_index_q;

		active    = e_band < rows;
		in_cell   = e_cell < cols;
		line_last = ({1'b0, e_line} + 1'b1) >= ch;
		x_last    = ({1'b0, e_xc} + 1'b1) >= cw;
		px_last   = ({1'b0, e_px} + 1'b1) >= iw;
		col_last  = (e_cell + 1'b1) >= cols;
		band_last = (e_band + 1'b1) >= rows;
		completes = active && in_cell && line_last && x_last;
	end

	baag_pkg::div_status_t div_status;

	// only a cell-closing pixel needs the divider
	assign in_ready = !(completes && !div_status.idle);
	assign accept   = in_valid && in_ready;

	always_comb begin
		n_px   = pixel_x_q;
		n_line = line_in_band_q;
		n_band = band_index_q;
		n_xc   = x_in_cell_q;
		n_cell = cell_index_q;
		if (accept) begin
			n_px   = e_px;
			n_line = e_line;
			n_band = e_band;
			n_xc   = e_xc;
			n_cell = e_cell;
			if (active) begin
				if (in_cell) begin
					if (x_last) begin
						n_xc   = '0;
						n_cell = e_cell + 1'b1;
					end else begin
						n_xc = e_xc + 1'b1;
					end
				end
				if (px_last) begin
					n_px   = '0;
					n_xc   = '0;
					n_cell = '0;
					if (line_last) begin
						n_line = '0;
						n_band = e_band + 1'b1;
					end else begin
						n_line = e_line + 1'b1;
					end
				end else begin
					n_px = e_px + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q      <= '0;
			line_in_band_q <= '0;
			band_index_q   <= '0;
			x_in_cell_q    <= '0;
			cell_index_q   <= '0;
		end else begin
			pixel_x_q      <= n_px;
			line_in_band_q <= n_line;
			band_index_q   <= n_band;
			x_in_cell_q    <= n_xc;
			cell_index_q   <= n_cell;
		end
	end

	// ---------------------------------------------------------------- column sums
	// RAM is read ahead at the next cell index, so its data lines up with
	// cell_index_q. A write on the previous edge to the same entry is forwarded.
	// Entries without a valid bit read as zero; frame_start drops all valid bits.
	logic [baag_pkg::MAX_COLUMNS-1:0] valid_q, valid_d;
	logic                             fwd_valid_q;
	logic [baag_pkg::COL_A_W-1:0]     fwd_addr_q;
	logic [baag_pkg::SUM_W-1:0]       fwd_data_q;

	logic [baag_pkg::SUM_W-1:0]   rd_data, stored, old_sum, sum_new, sum_wdata;
	logic                         sum_we;
	logic [baag_pkg::COL_A_W-1:0] sum_waddr;
	logic                         fwd_hit;

	always_comb begin
		fwd_hit = fwd_valid_q && (fwd_addr_q == cell_index_q[baag_pkg::COL_A_W-1:0]);
		if (fwd_hit) begin
			stored = fwd_data_q;
		end else if (valid_q[cell_index_q[baag_pkg::COL_A_W-1:0]]) begin
			stored = rd_data;
		end else begin
			stored = '0;
		end
		old_sum   = frame_start ? '0 : stored;
		sum_new   = old_sum + baag_pkg::SUM_W'(pixel_gray);
		sum_we    = accept && active && in_cell;
		sum_waddr = e_cell[baag_pkg::COL_A_W-1:0];
		// a closed cell starts over from zero
		sum_wdata = completes ? '0 : sum_new;

		valid_d = valid_q;
		if (accept && frame_start) valid_d = '0;
		if (sum_we) valid_d[sum_waddr] = 1'b1;
	end

	baag_ram #(
		.WIDTH (baag_pkg::SUM_W),
		.DEPTH (baag_pkg::MAX_COLUMNS)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (n_cell[baag_pkg::COL_A_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			valid_q     <= valid_d;
			fwd_valid_q <= sum_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= sum_waddr;
		fwd_data_q <= sum_wdata;
	end

	// ---------------------------------------------------------------- mean and glyph
	logic                        div_start;
	logic                        out_take;
	logic [baag_pkg::MEAN_W-1:0] div_mean;
	baag_pkg::cell_tag_t         start_tag, div_tag;

	assign div_start           = accept && completes;
	assign start_tag.row_end   = col_last;
	assign start_tag.frame_end = col_last && band_last;

	baag_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.num       (sum_new),
		.den       (area),
		.start_tag (start_tag),
		.take      (out_take),
		.status    (div_status),
		.mean      (div_mean),
		.tag       (div_tag)
	);

	logic                         out_valid_q;
	logic [baag_pkg::GLYPH_W-1:0] glyph_q;
	logic                         row_end_q;
	logic                         frame_end_q;

	assign out_take = div_status.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			glyph_q     <= baag_pkg::GLYPH_LUT[div_mean];
			row_end_q   <= div_tag.row_end;
			frame_end_q <= div_tag.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign glyph     = glyph_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	`BAAG_ASSERT_IMPLY(a_div_start_idle, div_start, div_status.idle, "cell closed while divider busy")
	`BAAG_ASSERT_NEXT(a_frame_clears_sums, accept && frame_start, $countones(valid_q) <= 1, "column sums not cleared at frame start")
	`BAAG_ASSERT_IMPLY(a_fwd_entry_valid, fwd_valid_q, valid_q[fwd_addr_q], "forwarded entry lacks valid bit")
	`BAAG_ASSERT_IMPLY(a_out_from_div, $rose(out_valid_q), $past(div_status.done), "output loaded without divider result")

endmodule

`default_nettype wire
